// ----- rtl/core/bmd_pkg.sv -----
// package for the broadcast message decoder: constants, result record, field helpers
`default_nettype none

package bmd_pkg;

    // packet geometry
    localparam int PKT_BYTES      = 32;
    localparam int MAX_STRING     = 19;
    localparam int HARD_STR_CAP   = 19;
    localparam int MIN_LENGTH     = 12;
    localparam int POS_W          = 5;

    // byte positions within a packet
    localparam logic [POS_W-1:0] POS_LENGTH     = 5'd0;
    localparam logic [POS_W-1:0] POS_PROTOCOL   = 5'd1;
    localparam logic [POS_W-1:0] POS_VERSION    = 5'd3;
    localparam logic [POS_W-1:0] POS_TYPE       = 5'd4;
    localparam logic [POS_W-1:0] POS_SENDER_LO  = 5'd9;
    localparam logic [POS_W-1:0] POS_SENDER_HI  = 5'd12;
    localparam logic [POS_W-1:0] POS_PAYLOAD_LO = 5'd13;
    localparam logic [POS_W-1:0] POS_PAYLOAD_HI = 5'd20;
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(PKT_BYTES - 1);
    localparam logic [POS_W-1:0] POS_NONE       = 5'd0;

    // string length byte positions per message type
    localparam logic [POS_W-1:0] LEN_POS_PAIR   = 5'd17;
    localparam logic [POS_W-1:0] LEN_POS_STRING = 5'd13;
    localparam logic [POS_W-1:0] LEN_POS_DPAIR  = 5'd21;

    // header byte values
    localparam logic [7:0] PROTOCOL_ID = 8'd1;
    localparam logic [7:0] VERSION_ID  = 8'd1;

    // message types
    localparam logic [7:0] TYPE_INT    = 8'd0;
    localparam logic [7:0] TYPE_PAIR   = 8'd1;
    localparam logic [7:0] TYPE_STRING = 8'd2;
    localparam logic [7:0] TYPE_DOUBLE = 8'd4;
    localparam logic [7:0] TYPE_DPAIR  = 8'd5;

    // result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // one result record
    typedef struct packed {
        logic        kind;
        logic [7:0]  char_value;
        logic [4:0]  char_index;
        logic        accepted;
        logic [7:0]  message_type;
        logic [31:0] sender_id;
        logic [31:0] integer_value;
        logic [4:0]  string_length;
        logic        last;
    } t_result;

    // position of the string length byte, POS_NONE when the type has no string
    function automatic logic [POS_W-1:0] len_pos_of(input logic [7:0] msg_type);
        logic [POS_W-1:0] pos;
        pos = POS_NONE;
        if (msg_type == TYPE_PAIR) begin
            pos = LEN_POS_PAIR;
        end else if (msg_type == TYPE_STRING) begin
            pos = LEN_POS_STRING;
        end else if (msg_type == TYPE_DPAIR) begin
            pos = LEN_POS_DPAIR;
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/broadcast_message_decoder.sv -----
// top level: byte stream radio packet decoder with string passthrough and summary
`default_nettype none

// Takes one packet byte per transfer and accepts a byte in every cycle unless
// the decoder stalls. Each byte is held in an input register and decoded from
// there; a string character enters the output queue as its byte is decoded,
// and the summary as the packet's last byte is. Results wait in a four-entry
// output queue, so the input keeps moving while the output side stalls until
// that queue is more than half full. The double-to-integer rounding runs in a
// two-stage unit fed from the payload bytes; the last byte of a packet is held
// back until that unit has settled, which never stalls the input, as the last
// byte always comes eleven bytes after payload byte 20. Any byte flagged with
// tuser starts a new packet and drops an unfinished one without a summary.
module broadcast_message_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] packet_byte
    input  wire logic [0:0]  i_s_tuser,   // [0] packet_start
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [95:0]      o_m_tdata,   // [7:0] char_value, [12:8] char_index,
                                          // [13] accepted, [21:14] message_type,
                                          // [53:22] sender_id, [85:54] integer_value,
                                          // [90:86] string_length, [95:91] zero
    output logic [0:0]       o_m_tuser,   // [0] result_kind
    output logic             o_m_tlast
);
    import bmd_pkg::*;

    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = PTR_W + 1;
    localparam logic [1:0] CONV_LATENCY = 2'd2;

    // input register
    logic       r_in_v;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // decoder state
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [7:0]       r_len,     n_len;
    logic             r_hdr,     n_hdr;
    logic [7:0]       r_type,    n_type;
    logic [31:0]      r_sender,  n_sender;
    logic [63:0]      r_payload, n_payload;
    logic [4:0]       r_scount,  n_scount;
    logic [4:0]       r_csent,   n_csent;
    logic [1:0]       r_conv_age;

    // double conversion pipeline
    logic        r_cv_neg, r_cv_nan, r_cv_sat, r_cv_small, r_cv_round, r_cv_sticky;
    logic [30:0] r_cv_q;
    logic [31:0] r_dbl;

    // output queue
    t_result          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    logic             w_take, w_pop, w_last, w_payload_wr;
    logic [POS_W-1:0] w_p, w_lp, w_start, w_room;
    logic [7:0]       w_cap;
    logic             w_emit_char, w_emit_sum;
    logic [1:0]       w_npush;
    t_result          w_char_res, w_sum_res;
    logic [31:0]      w_iv;

    // current position, a start flag forces byte 0
    assign w_p    = r_in_start ? POS_LENGTH : r_pos;
    assign w_last = (w_p >= POS_LAST);

    // decode one byte when the queue has room for two results and, for the last byte, the conversion has settled
    assign w_take = r_in_v && (r_count <= CNT_W'(FIFO_DEPTH - 2))
                    && !(w_last && (r_conv_age != CONV_LATENCY));
    assign o_s_tready = !r_in_v || w_take;

    // input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_v <= 1'b1;
        end else if (w_take) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser[0];
        end
    end

    // header and field capture
    always_comb begin
        n_len     = r_len;
        n_hdr     = r_hdr;
        n_type    = r_type;
        n_sender  = r_sender;
        n_payload = r_payload;
        if (w_p == POS_LENGTH) begin
            n_len     = r_in_byte;
            n_hdr     = 1'b0;
            n_type    = TYPE_INT;
            n_sender  = '0;
            n_payload = '0;
        end else if (w_p == POS_PROTOCOL) begin
            n_hdr = (r_in_byte == PROTOCOL_ID);
        end else if (w_p == POS_VERSION) begin
            n_hdr = r_hdr && (r_in_byte == VERSION_ID) && (r_len >= 8'(MIN_LENGTH));
        end else if (w_p == POS_TYPE) begin
            n_type = r_in_byte;
        end else if (w_p >= POS_SENDER_LO && w_p <= POS_SENDER_HI) begin
            n_sender[8*(2'(w_p - POS_SENDER_LO)) +: 8] = r_in_byte;
        end
        if (w_p >= POS_PAYLOAD_LO && w_p <= POS_PAYLOAD_HI) begin
            n_payload[8*(3'(w_p - POS_PAYLOAD_LO)) +: 8] = r_in_byte;
        end
    end

    assign w_payload_wr = (w_p == POS_LENGTH)
                          || (w_p >= POS_PAYLOAD_LO && w_p <= POS_PAYLOAD_HI);

    // string length capture and character passthrough
    assign w_lp    = len_pos_of(n_type);
    assign w_start = w_lp + 5'd1;
    assign w_room  = POS_W'(PKT_BYTES) - w_start;

    always_comb begin
        w_cap = r_in_byte;
        if (w_cap > {3'b0, w_room}) begin
            w_cap = {3'b0, w_room};
        end
        if (w_cap > 8'(MAX_STRING)) begin
            w_cap = 8'(MAX_STRING);
        end
        if (w_cap > 8'(HARD_STR_CAP)) begin
            w_cap = 8'(HARD_STR_CAP);
        end
    end

    always_comb begin
        n_scount    = (w_p == POS_LENGTH) ? 5'd0 : r_scount;
        n_csent     = (w_p == POS_LENGTH) ? 5'd0 : r_csent;
        w_emit_char = 1'b0;
        if (w_lp != POS_NONE) begin
            if (w_p == w_lp) begin
                n_scount = w_cap[4:0];
            end else if (n_hdr && (w_p >= w_start) && (n_csent < n_scount)) begin
                w_emit_char = 1'b1;
                n_csent     = n_csent + 5'd1;
            end
        end
    end

    assign w_emit_sum = w_last;
    assign n_pos      = w_last ? POS_LENGTH : (w_p + 5'd1);

    // summary integer by type
    always_comb begin
        w_iv = '0;
        if (n_type == TYPE_INT || n_type == TYPE_PAIR) begin
            w_iv = n_payload[31:0];
        end else if (n_type == TYPE_DOUBLE || n_type == TYPE_DPAIR) begin
            w_iv = r_dbl;
        end
    end

    always_comb begin
        w_char_res               = '0;
        w_char_res.kind          = KIND_CHAR;
        w_char_res.char_value    = r_in_byte;
        w_char_res.char_index    = r_csent;
        w_char_res.accepted      = 1'b1;
        w_char_res.last          = 1'b0;

        w_sum_res                = '0;
        w_sum_res.kind           = KIND_SUMMARY;
        w_sum_res.accepted       = n_hdr;
        w_sum_res.message_type   = n_hdr ? n_type : 8'd0;
        w_sum_res.sender_id      = n_hdr ? n_sender : 32'd0;
        w_sum_res.integer_value  = n_hdr ? w_iv : 32'd0;
        w_sum_res.string_length  = (n_hdr && w_lp != POS_NONE) ? n_scount : 5'd0;
        w_sum_res.last           = 1'b1;
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_hdr     <= 1'b0;
            r_type    <= '0;
            r_sender  <= '0;
            r_payload <= '0;
            r_scount  <= '0;
            r_csent   <= '0;
        end else if (w_take) begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_hdr     <= n_hdr;
            r_type    <= n_type;
            r_sender  <= n_sender;
            r_payload <= n_payload;
            r_scount  <= n_scount;
            r_csent   <= n_csent;
        end
    end

    // cycles since the payload last changed, saturating at the conversion latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_age <= '0;
        end else if (w_take && w_payload_wr) begin
            r_conv_age <= '0;
        end else if (r_conv_age != CONV_LATENCY) begin
            r_conv_age <= r_conv_age + 2'd1;
        end
    end

    // conversion stage 1: classify and align the mantissa
    logic        w_cv_neg;
    logic [10:0] w_cv_ex, w_sh_full;
    logic [51:0] w_cv_man;
    logic [52:0] w_m, w_q_full, w_mask;
    logic [5:0]  w_sh, w_shm1;

    assign w_cv_neg  = r_payload[63];
    assign w_cv_ex   = r_payload[62:52];
    assign w_cv_man  = r_payload[51:0];
    assign w_m       = {1'b1, w_cv_man};
    assign w_sh_full = 11'd1075 - w_cv_ex;
    assign w_sh      = w_sh_full[5:0];
    assign w_shm1    = w_sh - 6'd1;
    assign w_q_full  = w_m >> w_sh;
    assign w_mask    = (53'd1 << w_shm1) - 53'd1;

    always_ff @(posedge i_clk) begin
        r_cv_neg    <= w_cv_neg;
        r_cv_nan    <= (w_cv_ex == 11'h7FF) && (w_cv_man != '0);
        r_cv_sat    <= (w_cv_ex >= 11'd1054);
        r_cv_small  <= (w_cv_ex < 11'd1022);
        r_cv_q      <= w_q_full[30:0];
        r_cv_round  <= w_m[w_shm1];
        r_cv_sticky <= |(w_m & w_mask);
    end

    // conversion stage 2: round half to even, saturate and apply the sign
    logic        w_inc;
    logic [31:0] w_q1, w_dbl;

    assign w_inc = r_cv_round && (r_cv_sticky || r_cv_q[0]);
    assign w_q1  = {1'b0, r_cv_q} + {31'b0, w_inc};

    always_comb begin
        if (r_cv_nan || r_cv_small) begin
            w_dbl = '0;
        end else if (r_cv_sat) begin
            w_dbl = r_cv_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (r_cv_neg) begin
            w_dbl = 32'd0 - w_q1;
        end else begin
            w_dbl = w_q1[31] ? 32'h7FFF_FFFF : w_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dbl <= w_dbl;
    end

    // output queue, a character goes in ahead of a summary on the same byte
    assign w_pop   = o_m_tvalid && i_m_tready;
    assign w_npush = w_take ? ({1'b0, w_emit_char} + {1'b0, w_emit_sum}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (w_emit_char) begin
                r_fifo[r_wr] <= w_char_res;
                if (w_emit_sum) begin
                    r_fifo[r_wr + PTR_W'(1)] <= w_sum_res;
                end
            end else if (w_emit_sum) begin
                r_fifo[r_wr] <= w_sum_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(w_npush);
            r_rd    <= r_rd + PTR_W'(w_pop);
            r_count <= r_count + CNT_W'(w_npush) - CNT_W'(w_pop);
        end
    end

    // result port
    t_result w_head;
    assign w_head     = r_fifo[r_rd];
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {5'b0, w_head.string_length, w_head.integer_value,
                         w_head.sender_id, w_head.message_type, w_head.accepted,
                         w_head.char_index, w_head.char_value};
    assign o_m_tuser  = w_head.kind;
    assign o_m_tlast  = w_head.last;

`ifndef ASSERT_OFF
    // queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    // characters sent never pass the captured length
    a_chars_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_csent <= r_scount)
        else $error("more characters sent than string length");

    // only summaries close a packet
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser[0] == KIND_SUMMARY)))
        else $error("tlast on a character result");

    // a rejected packet reports no fields
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast && !o_m_tdata[13]) |-> (o_m_tdata[90:14] == '0))
        else $error("rejected summary carries data");

    // the last byte of a packet rewinds the position
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_last) |=> (r_pos == POS_LENGTH))
        else $error("position did not wrap after last byte");
`endif

endmodule

`default_nettype wire
